/* hw/rtl/drc_pkg.sv */
// Shared types, constants and helpers of the disjoint range coalescer.
// Used by the channel interfaces and every module of the block.
`timescale 1ns / 1ps

package drc_pkg;

  // Table geometry and value width.
  localparam int MAX_RANGES = 16;
  localparam int VALUE_BITS = 16;
  localparam int FIELD_W    = 16;
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [FIELD_W-1:0]    field_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_DUMP = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_LEFT    = 3'd1,
    ST_RIGHT   = 3'd2,
    ST_BRIDGE  = 3'd3,
    ST_COVERED = 3'd4,
    ST_FULL    = 3'd5,
    ST_REPORT  = 3'd6,
    ST_EMPTY   = 3'd7
  } status_t;

  // One stored range, inclusive bounds.
  typedef struct packed {
    val_t lo;
    val_t hi;
  } range_t;

  // Request to the range memory: one write and one read per cycle.
  typedef struct packed {
    logic   we;
    idx_t   waddr;
    range_t wdata;
    idx_t   raddr;
  } mem_req_t;

  // Flags of the shared compare unit, a against b.
  typedef struct packed {
    logic le;       // a <= b
    logic ge;       // a >= b
    logic inc_eq;   // a + 1 == b
    logic eq_inc;   // a == b + 1
  } cmp_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CHK_PREV,
    S_CHK_NEXT,
    S_SHDN,
    S_SHUP,
    S_INS,
    S_EMIT,
    S_DUMP_OUT
  } state_t;

  // Keep the low VALUE_BITS bits of an input field.
  function automatic val_t from_field(field_t f);
    logic [VALUE_BITS+FIELD_W-1:0] t;
    t = {{VALUE_BITS{1'b0}}, f};
    return t[VALUE_BITS-1:0];
  endfunction

  // Fit a stored value into an output field.
  function automatic field_t to_field(val_t v);
    logic [VALUE_BITS+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, v};
    return t[FIELD_W-1:0];
  endfunction

endpackage

/* hw/rtl/drc_if.sv */
// Valid/ready channel interfaces for the input items and the results.
// Depends on drc_pkg for the opcode and status types.
`timescale 1ns / 1ps

interface drc_in_if import drc_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t opcode;
  field_t  value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

interface drc_out_if import drc_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  field_t  range_first;
  field_t  range_final;
  logic    last_of_run;

  modport source (output valid, status, range_first, range_final, last_of_run, input ready);
  modport sink   (input valid, status, range_first, range_final, last_of_run, output ready);
endinterface

/* hw/rtl/drc_mem.sv */
// Range table storage: one write port and one registered read port.
// Depends on drc_pkg for the entry and request types.
`timescale 1ns / 1ps

module drc_mem import drc_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output range_t   rdata
);

  range_t mem [MAX_RANGES];

  // Write and read in the same cycle; the read returns the old contents.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

/* hw/rtl/drc_cmp.sv */
// Shared compare unit of the coalescer: order and adjacency of two values.
// Depends on drc_pkg for the value and flag types.
`timescale 1ns / 1ps

module drc_cmp import drc_pkg::*; (
  input  val_t     a,
  input  val_t     b,
  output cmp_res_t res
);

  logic [VALUE_BITS:0] a_inc;
  logic [VALUE_BITS:0] b_inc;

  // Adjacency is checked one bit wider so the top value does not wrap.
  assign a_inc = {1'b0, a} + 1'b1;
  assign b_inc = {1'b0, b} + 1'b1;

  assign res.le     = (a <= b);
  assign res.ge     = (a >= b);
  assign res.inc_eq = (a_inc == {1'b0, b});
  assign res.eq_inc = ({1'b0, a} == b_inc);

endmodule

/* hw/rtl/disjoint_range_coalescer.sv */
// Top level of the disjoint range coalescer: sequencer and result register.
// Depends on drc_pkg, drc_if, drc_mem and drc_cmp.
`timescale 1ns / 1ps
//
// The block keeps a sorted table of disjoint inclusive ranges in a small
// single-port-write memory. Items arrive on in_ch (opcode, value); results
// leave on out_ch (status, range_first, range_final, last_of_run). Both
// channels transfer when valid and ready are high at a rising clock edge.
// in_ch.ready is high only while the sequencer is idle, so one item is
// worked on at a time.
// An add walks the table one entry per cycle (every entry that starts at or
// below the value, plus the entry that stops the walk), classifies the value
// with the shared compare unit in S_CHK_PREV and S_CHK_NEXT, then moves
// entries in S_SHUP for an insert or in S_SHDN for a bridge, writes the new
// entry in S_INS and loads the result in S_EMIT, which waits while the output
// register is still full; the sequencer then returns to S_IDLE for the next item.
// A dump issues one result per cycle while out_ch.ready is high, one
// memory read per result. The pace is set by the memory's single read port.
// A result waits in the output register while the receiver stalls; the
// sequencer holds only while it has a further result to load. Synchronous
// reset empties the table (count to zero) at once; no clearing pass is needed.

module disjoint_range_coalescer import drc_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  drc_in_if.sink      in_ch,
  drc_out_if.source   out_ch
);

  state_t   state_r, state_nxt;
  cnt_t     count_r, count_nxt;
  cnt_t     p_r, p_nxt;
  cnt_t     idx_r, idx_nxt;
  val_t     value_r, value_nxt;
  range_t   prev_r, prev_nxt;
  range_t   next_r, next_nxt;
  logic     has_prev_r, has_prev_nxt;
  logic     has_next_r, has_next_nxt;
  logic     tl_r, tl_nxt;
  status_t  res_status_r, res_status_nxt;
  val_t     res_lo_r, res_lo_nxt;
  val_t     res_hi_r, res_hi_nxt;

  logic     out_valid_r;
  status_t  out_status_r;
  field_t   out_first_r;
  field_t   out_final_r;
  logic     out_last_r;

  logic     out_load;
  status_t  load_status;
  val_t     load_lo;
  val_t     load_hi;
  logic     load_last;

  mem_req_t mem_req;
  range_t   rdata;
  val_t     cmp_a;
  cmp_res_t cmp_res;

  logic     in_fire;
  logic     out_free;
  logic     last_scan;
  logic     covered;
  logic     touch_right;
  logic     full;
  logic     shdn_none;
  logic     dump_last;

  cnt_t     p_inc, p_dec, idx_inc, idx_inc2, idx_dec, idx_dec2, cnt_dec, cnt_inc;

  // Storage and the shared compare unit.
  drc_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  drc_cmp u_cmp (
    .a   (cmp_a),
    .b   (value_r),
    .res (cmp_res)
  );

  // Compare operand follows the sequencer step.
  always_comb begin
    unique case (state_r)
      S_SCAN:     cmp_a = rdata.lo;
      S_CHK_PREV: cmp_a = prev_r.hi;
      default:    cmp_a = next_r.lo;
    endcase
  end

  // Index arithmetic shared by both combinational blocks.
  assign p_inc    = cnt_t'(p_r + 1'b1);
  assign p_dec    = cnt_t'(p_r - 1'b1);
  assign idx_inc  = cnt_t'(idx_r + 1'b1);
  assign idx_inc2 = cnt_t'(idx_r + 2'd2);
  assign idx_dec  = cnt_t'(idx_r - 1'b1);
  assign idx_dec2 = cnt_t'(idx_r - 2'd2);
  assign cnt_dec  = cnt_t'(count_r - 1'b1);
  assign cnt_inc  = cnt_t'(count_r + 1'b1);

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign last_scan   = (p_inc == count_r);
  assign covered     = has_prev_r && cmp_res.ge;
  assign touch_right = has_next_r && cmp_res.eq_inc;
  assign full        = (count_r == cnt_t'(MAX_RANGES));
  assign shdn_none   = (p_inc == count_r);
  assign dump_last   = (idx_inc == count_r);

  assign in_ch.ready = (state_r == S_IDLE);

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.opcode == OP_DUMP) begin
            state_nxt = (count_r == '0) ? S_EMIT : S_DUMP_OUT;
          end else begin
            state_nxt = (count_r == '0) ? S_CHK_PREV : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!cmp_res.le || last_scan) begin
          state_nxt = S_CHK_PREV;
        end
      end
      S_CHK_PREV: state_nxt = covered ? S_EMIT : S_CHK_NEXT;
      S_CHK_NEXT: begin
        if (tl_r && touch_right) begin
          state_nxt = shdn_none ? S_EMIT : S_SHDN;
        end else if (tl_r || touch_right || full) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = (p_r == count_r) ? S_INS : S_SHUP;
        end
      end
      S_SHDN: begin
        if (idx_inc2 == count_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_SHUP: begin
        if (idx_dec == p_r) begin
          state_nxt = S_INS;
        end
      end
      S_INS: state_nxt = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DUMP_OUT: begin
        if (out_free && dump_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath control: memory requests, table bookkeeping and result loads.
  always_comb begin
    count_nxt      = count_r;
    p_nxt          = p_r;
    idx_nxt        = idx_r;
    value_nxt      = value_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    has_prev_nxt   = has_prev_r;
    has_next_nxt   = has_next_r;
    tl_nxt         = tl_r;
    res_status_nxt = res_status_r;
    res_lo_nxt     = res_lo_r;
    res_hi_nxt     = res_hi_r;
    mem_req.we     = 1'b0;
    mem_req.waddr  = idx_r[IDX_W-1:0];
    mem_req.wdata  = rdata;
    mem_req.raddr  = idx_r[IDX_W-1:0];
    out_load       = 1'b0;
    load_status    = res_status_r;
    load_lo        = res_lo_r;
    load_hi        = res_hi_r;
    load_last      = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        mem_req.raddr = '0;
        if (in_fire) begin
          value_nxt    = from_field(in_ch.value);
          p_nxt        = '0;
          idx_nxt      = '0;
          has_prev_nxt = 1'b0;
          has_next_nxt = 1'b0;
          res_status_nxt = ST_EMPTY;
          res_lo_nxt   = '0;
          res_hi_nxt   = '0;
        end
      end
      // Walk entries until the first start above the value.
      S_SCAN: begin
        if (cmp_res.le) begin
          prev_nxt      = rdata;
          has_prev_nxt  = 1'b1;
          p_nxt         = p_inc;
          mem_req.raddr = p_inc[IDX_W-1:0];
        end else begin
          next_nxt     = rdata;
          has_next_nxt = 1'b1;
        end
      end
      S_CHK_PREV: begin
        if (covered) begin
          res_status_nxt = ST_COVERED;
          res_lo_nxt     = prev_r.lo;
          res_hi_nxt     = prev_r.hi;
        end
        tl_nxt = has_prev_r && cmp_res.inc_eq;
      end
      S_CHK_NEXT: begin
        if (tl_r && touch_right) begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = p_dec[IDX_W-1:0];
          mem_req.wdata  = '{lo: prev_r.lo, hi: next_r.hi};
          res_status_nxt = ST_BRIDGE;
          res_lo_nxt     = prev_r.lo;
          res_hi_nxt     = next_r.hi;
          idx_nxt        = p_r;
          mem_req.raddr  = p_inc[IDX_W-1:0];
          if (shdn_none) begin
            count_nxt = cnt_dec;
          end
        end else if (tl_r) begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = p_dec[IDX_W-1:0];
          mem_req.wdata  = '{lo: prev_r.lo, hi: value_r};
          res_status_nxt = ST_LEFT;
          res_lo_nxt     = prev_r.lo;
          res_hi_nxt     = value_r;
        end else if (touch_right) begin
          mem_req.we     = 1'b1;
          mem_req.waddr  = p_r[IDX_W-1:0];
          mem_req.wdata  = '{lo: value_r, hi: next_r.hi};
          res_status_nxt = ST_RIGHT;
          res_lo_nxt     = value_r;
          res_hi_nxt     = next_r.hi;
        end else if (full) begin
          res_status_nxt = ST_FULL;
          res_lo_nxt     = value_r;
          res_hi_nxt     = value_r;
        end else begin
          res_status_nxt = ST_NEW;
          res_lo_nxt     = value_r;
          res_hi_nxt     = value_r;
          idx_nxt        = count_r;
          mem_req.raddr  = cnt_dec[IDX_W-1:0];
        end
      end
      // Close the gap left by the absorbed right range.
      S_SHDN: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r[IDX_W-1:0];
        mem_req.wdata = rdata;
        if (idx_inc2 == count_r) begin
          count_nxt = cnt_dec;
        end else begin
          idx_nxt       = idx_inc;
          mem_req.raddr = idx_inc2[IDX_W-1:0];
        end
      end
      // Open a slot for the new range, moving from the top down.
      S_SHUP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r[IDX_W-1:0];
        mem_req.wdata = rdata;
        idx_nxt       = idx_dec;
        mem_req.raddr = idx_dec2[IDX_W-1:0];
      end
      S_INS: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = p_r[IDX_W-1:0];
        mem_req.wdata = '{lo: value_r, hi: value_r};
        count_nxt     = cnt_inc;
      end
      S_EMIT: begin
        out_load = out_free;
      end
      // One report per cycle; the read address stays put while stalled.
      S_DUMP_OUT: begin
        load_status = ST_REPORT;
        load_lo     = rdata.lo;
        load_hi     = rdata.hi;
        load_last   = dump_last;
        if (out_free) begin
          out_load      = 1'b1;
          idx_nxt       = idx_inc;
          mem_req.raddr = idx_inc[IDX_W-1:0];
        end
      end
      default: begin
        mem_req.raddr = '0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    idx_r        <= idx_nxt;
    value_r      <= value_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    has_prev_r   <= has_prev_nxt;
    has_next_r   <= has_next_nxt;
    tl_r         <= tl_nxt;
    res_status_r <= res_status_nxt;
    res_lo_r     <= res_lo_nxt;
    res_hi_r     <= res_hi_nxt;
  end

  // Output register: holds a result until the receiver takes the transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= load_status;
      out_first_r  <= to_field(load_lo);
      out_final_r  <= to_field(load_hi);
      out_last_r   <= load_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.range_first = out_first_r;
  assign out_ch.range_final = out_final_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

/* hw/rtl/drc_checker.sv */
// Port-level checks of the disjoint range coalescer, bound to the top level.
// Depends on drc_pkg for the status codes.
`timescale 1ns / 1ps

module drc_checker import drc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input field_t      range_first,
  input field_t      range_final,
  input logic        last_of_run
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({status, range_first, range_final, last_of_run}))
    else $error("result changed while stalled");

  // The sequencer is busy right after it takes an item.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // Only range reports may be followed by more results of the same item.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != ST_REPORT) |-> last_of_run)
    else $error("single result without last mark");

  // An empty report carries zero bounds.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_EMPTY) |-> (range_first == '0) && (range_final == '0))
    else $error("empty report with bounds");

  // A new or dropped value is a one-value range.
  a_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((status == ST_NEW) || (status == ST_FULL)) |->
      (range_first == range_final))
    else $error("new range not a single value");

endmodule

bind disjoint_range_coalescer drc_checker u_drc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .range_first (out_ch.range_first),
  .range_final (out_ch.range_final),
  .last_of_run (out_ch.last_of_run)
);

/* tb/tb_disjoint_range_coalescer.sv */
// Self-checking testbench for the disjoint range coalescer.
// Depends on drc_pkg, the drc_if channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_disjoint_range_coalescer import drc_pkg::*; ();

  localparam int RANDOM_ITEMS   = 225;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 60;

  // One input item and one result as the testbench sees them.
  typedef struct {
    opcode_t op;
    field_t  value;
  } range_item_t;

  typedef struct {
    status_t status;
    field_t  lo;
    field_t  hi;
    logic    last_of_run;
  } range_outcome_t;

  logic clk;
  logic rst_n;

  drc_in_if  in_ch ();
  drc_out_if out_ch ();

  disjoint_range_coalescer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Items still to be sent, and the results they are known to cause.
  range_item_t    item_q[$];
  range_outcome_t outcome_q[$];

  // Private copy of the range table.
  val_t tbl_lo [MAX_RANGES];
  val_t tbl_hi [MAX_RANGES];
  int   tbl_count;

  int error_count;
  int items_sent;
  int dumps_sent;
  int results_seen;
  int status_seen [8];

  int in_gap, in_calm;
  int out_gap, out_calm;
  int quiet_cycles;
  range_item_t    next_item;
  range_outcome_t head;

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap before the next transfer: mostly short, a few long, and now and then
  // a stretch with no gaps at all.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_outcome(status_t st, val_t lo, val_t hi, logic last);
    range_outcome_t o;
    o.status      = st;
    o.lo          = field_t'(lo);
    o.hi          = field_t'(hi);
    o.last_of_run = last;
    outcome_q.insert(outcome_q.size(), o);
  endfunction

  // Apply one accepted item to the private table and queue what it causes.
  function automatic void coalesce_item(opcode_t op, field_t raw);
    val_t   v;
    int     p;
    logic   joins_left, joins_right;
    longint v_l;
    v   = val_t'(raw);
    v_l = longint'(v);
    if (op == OP_DUMP) begin
      if (tbl_count == 0) begin
        push_outcome(ST_EMPTY, '0, '0, 1'b1);
      end else begin
        for (int i = 0; i < tbl_count; i++)
          push_outcome(ST_REPORT, tbl_lo[i], tbl_hi[i], (i + 1 == tbl_count));
      end
      return;
    end
    // Find the first range that starts above the value.
    p = 0;
    while (p < tbl_count && tbl_lo[p] <= v) p++;
    if (p > 0 && tbl_hi[p-1] >= v) begin
      push_outcome(ST_COVERED, tbl_lo[p-1], tbl_hi[p-1], 1'b1);
      return;
    end
    joins_left  = (p > 0) && (longint'(tbl_hi[p-1]) + 1 == v_l);
    joins_right = (p < tbl_count) && (longint'(tbl_lo[p]) == v_l + 1);
    if (joins_left && joins_right) begin
      // The left range swallows the right one; later entries move down.
      tbl_hi[p-1] = tbl_hi[p];
      for (int i = p; i + 1 < tbl_count; i++) begin
        tbl_lo[i] = tbl_lo[i+1];
        tbl_hi[i] = tbl_hi[i+1];
      end
      tbl_count--;
      push_outcome(ST_BRIDGE, tbl_lo[p-1], tbl_hi[p-1], 1'b1);
    end else if (joins_left) begin
      tbl_hi[p-1] = v;
      push_outcome(ST_LEFT, tbl_lo[p-1], v, 1'b1);
    end else if (joins_right) begin
      tbl_lo[p] = v;
      push_outcome(ST_RIGHT, v, tbl_hi[p], 1'b1);
    end else if (tbl_count >= MAX_RANGES) begin
      push_outcome(ST_FULL, v, v, 1'b1);
    end else begin
      // Open a slot at the sorted position for a single-value range.
      for (int i = tbl_count; i > p; i--) begin
        tbl_lo[i] = tbl_lo[i-1];
        tbl_hi[i] = tbl_hi[i-1];
      end
      tbl_lo[p] = v;
      tbl_hi[p] = v;
      tbl_count++;
      push_outcome(ST_NEW, v, v, 1'b1);
    end
  endfunction

  task automatic queue_add(int v);
    range_item_t it;
    it.op    = OP_ADD;
    it.value = field_t'(v);
    item_q.insert(item_q.size(), it);
  endtask

  task automatic queue_dump();
    range_item_t it;
    it.op    = OP_DUMP;
    it.value = field_t'($urandom_range(0, 65535));
    item_q.insert(item_q.size(), it);
  endtask

  // Input driver: one transfer per accepted item, gaps between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        coalesce_item(in_ch.opcode, in_ch.value);
        items_sent++;
        if (in_ch.opcode == OP_DUMP) dumps_sent++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Hold the offered item until it is taken.
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        next_item = item_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= next_item.op;
        in_ch.value  <= next_item.value;
        in_gap = pick_gap(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare each transfer with the oldest queued outcome and
  // stall the output at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (outcome_q.size() == 0) begin
          $error("result with nothing outstanding: status %0d, range %0d..%0d",
                 out_ch.status, out_ch.range_first, out_ch.range_final);
          error_count++;
        end else begin
          head = outcome_q.pop_front();
          status_seen[head.status]++;
          if (out_ch.status !== head.status) begin
            $error("status mismatch: expected %s (%0d), actual %0d",
                   head.status.name(), head.status, out_ch.status);
            error_count++;
          end
          if (out_ch.range_first !== head.lo) begin
            $error("range_first mismatch: expected %0d, actual %0d",
                   head.lo, out_ch.range_first);
            error_count++;
          end
          if (out_ch.range_final !== head.hi) begin
            $error("range_final mismatch: expected %0d, actual %0d",
                   head.hi, out_ch.range_final);
            error_count++;
          end
          if (out_ch.last_of_run !== head.last_of_run) begin
            $error("last_of_run mismatch: expected %0b, actual %0b",
                   head.last_of_run, out_ch.last_of_run);
            error_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap = pick_gap(out_calm);
      end
    end
  end

  // Watchdog: give up when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", quiet_cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int anchors[$];
    int base, span, burst, r, n;

    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_ADD;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    tbl_count    = 0;
    error_count  = 0;
    items_sent   = 0;
    dumps_sent   = 0;
    results_seen = 0;
    in_gap       = 0;
    in_calm      = 0;
    out_gap      = 0;
    out_calm     = 0;
    quiet_cycles = 0;
    foreach (status_seen[i]) status_seen[i] = 0;

    // Directed part: empty dump, new, covered, left and right joins, a
    // bridge, both value extremes, then a full table and a dropped value.
    queue_dump();
    queue_add(0);
    queue_add(0);
    queue_add(1);
    queue_add(3);
    queue_add(2);
    queue_add(65535);
    queue_add(65534);
    queue_dump();
    for (int k = 10; k <= 36; k += 2) queue_add(k);
    queue_add(100);
    queue_dump();

    // Random part: bursts of values clustered in a window so that ranges
    // grow, touch and bridge, mixed with stray values and dumps.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (anchors.size() > 0 && $urandom_range(0, 2) == 0) begin
        base = anchors[$urandom_range(0, anchors.size() - 1)];
      end else begin
        base = $urandom_range(0, 65535);
        anchors.insert(anchors.size(), base);
      end
      span  = $urandom_range(4, 40);
      burst = $urandom_range(4, 16);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 8)
          queue_dump();
        else if (r < 16)
          queue_add($urandom_range(0, 65535));
        else if (r < 18)
          queue_add($urandom_range(0, 3));
        else if (r < 20)
          queue_add($urandom_range(65532, 65535));
        else
          queue_add(base + $urandom_range(0, span));
        n++;
      end
      queue_dump();
      n++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every item is sent and every outcome has arrived.
    @(negedge clk);
    while (item_q.size() != 0 || in_ch.valid || outcome_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (outcome_q.size() != 0) begin
      $error("%0d results never arrived", outcome_q.size());
      error_count++;
    end

    $display("ran %0d items (%0d dumps) and checked %0d results", items_sent,
             dumps_sent, results_seen);
    $display("new %0d, left %0d, right %0d, bridge %0d, covered %0d, full %0d,",
             status_seen[ST_NEW], status_seen[ST_LEFT], status_seen[ST_RIGHT],
             status_seen[ST_BRIDGE], status_seen[ST_COVERED], status_seen[ST_FULL]);
    $display("report %0d, empty %0d", status_seen[ST_REPORT], status_seen[ST_EMPTY]);
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
